// File: design/scld_pkg.sv
// shared types and constants for the slice cycle loss detector
// no dependencies; imported by the top level and the output buffer
package scld_pkg;

  localparam int unsigned MbW = 16;

  typedef struct packed {
    logic           loss;
    logic           exp_valid;
    logic [MbW-1:0] exp_mb;
  } scld_result_t;

endpackage

// File: design/scld_out_buf.sv
// two-entry result buffer between the detector core and the output channel
// depends on scld_pkg for the result type
module scld_out_buf (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  scld_pkg::scld_result_t push_data_i,
  output logic                  full_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output scld_pkg::scld_result_t out_data_o
);
  import scld_pkg::*;

  scld_result_t slot_q [2];
  logic         wr_ptr_q, wr_ptr_d;
  logic         rd_ptr_q, rd_ptr_d;
  logic [1:0]   cnt_q, cnt_d;
  logic         pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign full_o      = (cnt_q == 2'd2);
  assign out_data_o  = slot_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // payload slots, no reset
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: design/slice_cycle_loss_detector_top.sv
// slice cycle loss detector: learns the slice address cycle, then flags lost slices
// depends on scld_pkg and scld_out_buf
//
// usage:
//   input channel: one beat per received slice, carrying slice_first_mb_i,
//   handshake in_valid_i / in_ready_o
//   output channel: exactly one result beat per input beat, in order, carrying
//   loss_detected_o, expected_valid_o, expected_first_mb_o,
//   handshake out_valid_o / out_ready_i
//   result path: each result is registered in the result buffer when its beat is taken
//   throughput: one beat per cycle while the result buffer has room; the next prediction
//   address is computed from the current compare and the table read at it is registered,
//   so the table read port sets the pace
//   stall: a two-entry result buffer lets one more input beat in while a
//   result waits; in_ready_o drops only when both entries are occupied
//   reset: learning restarts at table slot 0, no cycle known; the table
//   contents are left as they are and are only read after being rewritten
//   if the table fills without finding a cycle, all later results are zero
//   until the next reset
module slice_cycle_loss_detector_top #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [scld_pkg::MbW-1:0] slice_first_mb_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     loss_detected_o,
  output logic                     expected_valid_o,
  output logic [scld_pkg::MbW-1:0] expected_first_mb_o
);
  import scld_pkg::*;

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);

  // detector state codes
  localparam logic [1:0] StLearn   = 2'd0;
  localparam logic [1:0] StPredict = 2'd1;
  localparam logic [1:0] StDead    = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;      // learning slot or wrapped prediction index
  logic [IdxW-1:0] len_q, len_d;      // cycle length once known
  logic [MbW-1:0]  first_q, first_d;  // copy of table slot 0, avoids a second read

  // address table, one write and one registered read per cycle
  logic [MbW-1:0]  table_q [TABLE_DEPTH];
  logic [MbW-1:0]  rd_data_q;         // table entry at idx_q
  logic            wr_en;

  logic            accept;
  logic            buf_full;
  logic            match;
  logic            mismatch;
  logic [IdxW:0]   step_sum;
  scld_result_t    res;
  scld_result_t    out_res;

  assign in_ready_o = !buf_full;
  assign accept     = in_valid_i && in_ready_o;

  assign match    = (idx_q != '0) && (slice_first_mb_i == first_q);
  assign mismatch = (rd_data_q != slice_first_mb_i);
  // skip one extra slot after a miss
  assign step_sum = {1'b0, idx_q} + (mismatch ? (IdxW+1)'(2) : (IdxW+1)'(1));

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    len_d   = len_q;
    first_d = first_q;
    wr_en   = 1'b0;
    res     = '0;
    if (accept) begin
      unique case (state_q)
        StLearn: begin
          wr_en = 1'b1;
          if (idx_q == '0) begin
            first_d = slice_first_mb_i;
          end
          if (match) begin
            // cycle found: predict slot 0 right away, which equals this input
            state_d       = StPredict;
            len_d         = idx_q;
            idx_d         = (idx_q == IdxW'(1)) ? '0 : IdxW'(1);
            res.exp_valid = 1'b1;
            res.exp_mb    = slice_first_mb_i;
          end else if (idx_q == IdxW'(TABLE_DEPTH - 1)) begin
            state_d = StDead;
          end else begin
            idx_d = idx_q + IdxW'(1);
          end
        end
        StPredict: begin
          res.exp_valid = 1'b1;
          res.exp_mb    = rd_data_q;
          res.loss      = mismatch;
          idx_d         = (step_sum >= {1'b0, len_q}) ? '0 : step_sum[IdxW-1:0];
        end
        StDead: begin
          res = '0;
        end
        default: begin
          res = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLearn;
      idx_q   <= '0;
      len_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      len_q   <= len_d;
    end
  end

  // slot 0 copy only matters once written
  always_ff @(posedge clk_i) begin
    first_q <= first_d;
  end

  // table access: read address follows the next index so the registered read
  // holds the prediction for the following beat
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      table_q[idx_q] <= slice_first_mb_i;
    end
    rd_data_q <= table_q[idx_d];
  end

  scld_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_res)
  );

  assign loss_detected_o     = out_res.loss;
  assign expected_valid_o    = out_res.exp_valid;
  assign expected_first_mb_o = out_res.exp_mb;

endmodule
